FILE: rtl/phfc_pkg.sv
package phfc_pkg;

  // Fixed field widths.
  localparam int unsigned TEMP_W     = 13;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned KDUR_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Curve corners in 1/16 degree C: 25 C and 60 C.
  localparam logic signed [TEMP_W-1:0] T_LOW  = 13'sd400;
  localparam logic signed [TEMP_W-1:0] T_HIGH = 13'sd960;

  // Offset above the lower corner fits in ten bits (at most 559).
  localparam int unsigned DIFF_W = 10;

  // The curve span of 560 is split as 16 * 35: a shift, then a reciprocal multiply.
  localparam int unsigned CURVE_SHIFT = 4;
  localparam int unsigned Curve_Div   = 35;
  localparam int unsigned DIV_GUARD   = 6;

  // Register reset values.
  localparam logic signed [TEMP_W-1:0] RST_ON_TH  = 13'sd640;
  localparam logic signed [TEMP_W-1:0] RST_OFF_TH = 13'sd560;
  localparam logic [CFG_DATA_W-1:0] RST_DUTY_MIN  = 16'd256;
  localparam logic [CFG_DATA_W-1:0] RST_DUTY_MAX  = 16'd1023;
  localparam logic [KDUR_W-1:0]     RST_KICK_DUR  = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] RST_KICK_DUTY = 16'd1023;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_TH         = 3'd0,
    REG_OFF_TH        = 3'd1,
    REG_DUTY_MIN      = 3'd2,
    REG_DUTY_MAX_NORM = 3'd3,
    REG_DUTY_MAX_BNCH = 3'd4,
    REG_KICK_DUR      = 3'd5,
    REG_KICK_DUTY     = 3'd6
  } cfg_idx_e;

  // Decisions passed from the control stage to the curve stage.
  typedef struct packed {
    logic pump_on;
    logic kicking;
    logic bench;
    logic clamp_lo;
    logic clamp_hi;
  } phfc_flags_t;

endpackage

FILE: rtl/phfc_regs.sv
module phfc_regs #(
  parameter int unsigned DUTY_BITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [phfc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [phfc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic signed [phfc_pkg::TEMP_W-1:0]   on_th_o,
  output logic signed [phfc_pkg::TEMP_W-1:0]   off_th_o,
  output logic [DUTY_BITS-1:0]                 duty_min_o,
  output logic [DUTY_BITS-1:0]                 duty_max_norm_o,
  output logic [DUTY_BITS-1:0]                 duty_max_bnch_o,
  output logic [phfc_pkg::KDUR_W-1:0]          kick_dur_o,
  output logic [DUTY_BITS-1:0]                 kick_duty_o
);
  import phfc_pkg::*;

  logic signed [TEMP_W-1:0] on_th_q, off_th_q;
  logic [DUTY_BITS-1:0]     duty_min_q, duty_max_norm_q, duty_max_bnch_q, kick_duty_q;
  logic [KDUR_W-1:0]        kick_dur_q;

  // Register writes; values are truncated to the register width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_th_q         <= RST_ON_TH;
      off_th_q        <= RST_OFF_TH;
      duty_min_q      <= RST_DUTY_MIN[DUTY_BITS-1:0];
      duty_max_norm_q <= RST_DUTY_MAX[DUTY_BITS-1:0];
      duty_max_bnch_q <= RST_DUTY_MAX[DUTY_BITS-1:0];
      kick_dur_q      <= RST_KICK_DUR;
      kick_duty_q     <= RST_KICK_DUTY[DUTY_BITS-1:0];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_ON_TH:         on_th_q         <= signed'(cfg_data_i[TEMP_W-1:0]);
        REG_OFF_TH:        off_th_q        <= signed'(cfg_data_i[TEMP_W-1:0]);
        REG_DUTY_MIN:      duty_min_q      <= cfg_data_i[DUTY_BITS-1:0];
        REG_DUTY_MAX_NORM: duty_max_norm_q <= cfg_data_i[DUTY_BITS-1:0];
        REG_DUTY_MAX_BNCH: duty_max_bnch_q <= cfg_data_i[DUTY_BITS-1:0];
        REG_KICK_DUR:      kick_dur_q      <= cfg_data_i[KDUR_W-1:0];
        REG_KICK_DUTY:     kick_duty_q     <= cfg_data_i[DUTY_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign on_th_o         = on_th_q;
  assign off_th_o        = off_th_q;
  assign duty_min_o      = duty_min_q;
  assign duty_max_norm_o = duty_max_norm_q;
  assign duty_max_bnch_o = duty_max_bnch_q;
  assign kick_dur_o      = kick_dur_q;
  assign kick_duty_o     = kick_duty_q;

endmodule

FILE: rtl/phfc_ctrl.sv
module phfc_ctrl #(
  parameter int unsigned DUTY_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic signed [phfc_pkg::TEMP_W-1:0]  temp_i,
  input  logic [phfc_pkg::TIME_W-1:0]         now_i,
  input  logic                                bench_i,
  input  logic signed [phfc_pkg::TEMP_W-1:0]  on_th_i,
  input  logic signed [phfc_pkg::TEMP_W-1:0]  off_th_i,
  input  logic [phfc_pkg::KDUR_W-1:0]         kick_dur_i,
  input  logic [DUTY_BITS-1:0]                duty_min_i,
  input  logic [DUTY_BITS-1:0]                duty_max_norm_i,
  input  logic [DUTY_BITS-1:0]                duty_max_bnch_i,
  output phfc_pkg::phfc_flags_t               flags_o,
  output logic signed [DUTY_BITS+10:0]        prod_o
);
  import phfc_pkg::*;

  localparam int unsigned PROD_W = DUTY_BITS + 11;

  logic              on_q, on_d;
  logic              kick_q, kick_d;
  logic [TIME_W-1:0] kick_start_q, kick_start_d;
  logic [TIME_W-1:0] elapsed;
  logic              kicking;

  logic [DUTY_BITS-1:0]      duty_hi;
  logic signed [DUTY_BITS:0] span;
  logic [TEMP_W-1:0]         diff_full;
  logic signed [DIFF_W:0]    diff_s;
  logic signed [PROD_W-1:0]  prod_d;

  phfc_flags_t              flags_d, flags_q;
  logic signed [PROD_W-1:0] prod_q;

  // Hysteresis and kickstart update for the item being loaded.
  always_comb begin
    on_d         = on_q;
    kick_d       = kick_q;
    kick_start_d = kick_start_q;
    if (!on_q) begin
      if (temp_i > on_th_i) begin
        on_d         = 1'b1;
        kick_d       = 1'b1;
        kick_start_d = now_i;
      end
    end else if (temp_i < off_th_i) begin
      on_d   = 1'b0;
      kick_d = 1'b0;
    end
    elapsed = now_i - kick_start_d;
    kicking = on_d && kick_d && (elapsed < {{(TIME_W-KDUR_W){1'b0}}, kick_dur_i});
    if (on_d && kick_d && !kicking) begin
      kick_d = 1'b0;
    end
  end

  // Curve product: offset above the lower corner times the signed duty span.
  always_comb begin
    duty_hi   = bench_i ? duty_max_bnch_i : duty_max_norm_i;
    span      = signed'({1'b0, duty_hi}) - signed'({1'b0, duty_min_i});
    diff_full = unsigned'(temp_i - T_LOW);
    diff_s    = signed'({1'b0, diff_full[DIFF_W-1:0]});
    prod_d    = PROD_W'(diff_s) * PROD_W'(span);
  end

  always_comb begin
    flags_d.pump_on  = on_d;
    flags_d.kicking  = kicking;
    flags_d.bench    = bench_i;
    flags_d.clamp_lo = (temp_i <= T_LOW);
    flags_d.clamp_hi = (temp_i >= T_HIGH);
  end

  // Block state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q         <= 1'b0;
      kick_q       <= 1'b0;
      kick_start_q <= '0;
    end else if (load_i) begin
      on_q         <= on_d;
      kick_q       <= kick_d;
      kick_start_q <= kick_start_d;
    end
  end

  // Stage register toward the curve stage.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      flags_q <= flags_d;
      prod_q  <= prod_d;
    end
  end

  assign flags_o = flags_q;
  assign prod_o  = prod_q;

endmodule

FILE: rtl/phfc_curve.sv
module phfc_curve #(
  parameter int unsigned DUTY_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  phfc_pkg::phfc_flags_t        flags_i,
  input  logic signed [DUTY_BITS+10:0] prod_i,
  input  logic [DUTY_BITS-1:0]         duty_min_i,
  input  logic [DUTY_BITS-1:0]         duty_max_norm_i,
  input  logic [DUTY_BITS-1:0]         duty_max_bnch_i,
  input  logic [DUTY_BITS-1:0]         kick_duty_i,
  output logic [DUTY_BITS-1:0]         duty_o,
  output logic                         pump_on_o,
  output logic                         kicking_o
);
  import phfc_pkg::*;

  localparam int unsigned PROD_W = DUTY_BITS + 11;
  // Magnitude of the product stays below 2^(DUTY_BITS+10).
  localparam int unsigned MAG_W  = DUTY_BITS + 10;
  localparam int unsigned Y_W    = MAG_W - CURVE_SHIFT;
  localparam int unsigned SH     = Y_W + DIV_GUARD;
  localparam int unsigned RCP_W  = SH - 4;
  localparam int unsigned FULL_W = Y_W + RCP_W;
  // Rounded-up reciprocal; exact floor division for every Y_W-bit value.
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SH) + 64'(Curve_Div) - 64'd1) / 64'(Curve_Div));

  logic                      neg;
  logic [PROD_W-1:0]         mag;
  logic [Y_W-1:0]            y;
  logic [FULL_W-1:0]         full;
  logic [DUTY_BITS-1:0]      quo;
  logic [DUTY_BITS-1:0]      duty_hi;
  logic signed [DUTY_BITS:0] curve_s;
  logic [DUTY_BITS-1:0]      duty_d;

  // Truncating division of the product by the curve span, then the offset.
  always_comb begin
    neg     = prod_i[PROD_W-1];
    mag     = neg ? unsigned'(-prod_i) : unsigned'(prod_i);
    y       = mag[MAG_W-1:CURVE_SHIFT];
    full    = FULL_W'(y) * FULL_W'(RECIP);
    quo     = full[SH+DUTY_BITS-1:SH];
    curve_s = neg ? signed'({1'b0, duty_min_i}) - signed'({1'b0, quo})
                  : signed'({1'b0, duty_min_i}) + signed'({1'b0, quo});
  end

  // Output selection: off, kickstart, clamps, then the curve.
  always_comb begin
    duty_hi = flags_i.bench ? duty_max_bnch_i : duty_max_norm_i;
    if (!flags_i.pump_on) begin
      duty_d = '0;
    end else if (flags_i.kicking) begin
      duty_d = kick_duty_i;
    end else if (flags_i.clamp_lo) begin
      duty_d = duty_min_i;
    end else if (flags_i.clamp_hi) begin
      duty_d = duty_hi;
    end else begin
      duty_d = curve_s[DUTY_BITS-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      duty_o    <= duty_d;
      pump_on_o <= flags_i.pump_on;
      kicking_o <= flags_i.kicking;
    end
  end

endmodule

FILE: rtl/pump_hysteresis_fan_curve.sv
// Pump fan-curve controller with on/off hysteresis and kickstart. Each input
// transaction carries one temperature sample, a millisecond timestamp and a
// benchmark flag and yields exactly one output transaction with the PWM duty.
// The block takes one transaction per cycle while the output side does not
// stall. The input register loads at the accepting edge. The control stage
// (hysteresis, kickstart timing and the curve multiply) adds one register. The
// curve stage (reciprocal division and output register) adds another, so the
// result passes through the input, control and curve registers in that order.
// Stalls on the output side back up through the three stages, so up to three
// transactions are held in flight. Registers must be written only while the
// block holds no transaction; the block itself does not enforce this.
module pump_hysteresis_fan_curve #(
  parameter int unsigned DUTY_BITS = 10
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration writes.
  input  logic                                    cfg_we_i,
  input  logic [phfc_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [phfc_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // Sample stream.
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // temperature [12:0], now_ms [44:13], bench_mode [45], zero [47:46]
  input  logic [47:0]                             s_axis_tdata,
  // Duty stream.
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // duty [DUTY_BITS-1:0], pump_on [DUTY_BITS], kicking [DUTY_BITS+1], zero fill
  output logic [((DUTY_BITS+2+7)/8)*8-1:0]        m_axis_tdata
);
  import phfc_pkg::*;

  localparam int unsigned OUT_W = ((DUTY_BITS + 2 + 7) / 8) * 8;

  logic signed [TEMP_W-1:0] on_th, off_th;
  logic [DUTY_BITS-1:0]     duty_min, duty_max_norm, duty_max_bnch, kick_duty;
  logic [KDUR_W-1:0]        kick_dur;

  logic v0_q, v1_q, v2_q;
  logic load0, load1, load2;
  logic free0, free1, free2;

  logic signed [TEMP_W-1:0] temp_q;
  logic [TIME_W-1:0]        now_q;
  logic                     bench_q;

  phfc_flags_t                  flags;
  logic signed [DUTY_BITS+10:0] prod;
  logic [DUTY_BITS-1:0]         out_duty;
  logic                         out_pump_on;
  logic                         out_kicking;

  phfc_regs #(.DUTY_BITS(DUTY_BITS)) u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .on_th_o         (on_th),
    .off_th_o        (off_th),
    .duty_min_o      (duty_min),
    .duty_max_norm_o (duty_max_norm),
    .duty_max_bnch_o (duty_max_bnch),
    .kick_dur_o      (kick_dur),
    .kick_duty_o     (kick_duty)
  );

  // Pipeline advance: a stage loads when it is empty or its content moves on.
  assign free2 = !v2_q || m_axis_tready;
  assign load2 = v1_q && free2;
  assign free1 = !v1_q || load2;
  assign load1 = v0_q && free1;
  assign free0 = !v0_q || load1;
  assign load0 = s_axis_tvalid && free0;

  assign s_axis_tready = free0;
  assign m_axis_tvalid = v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (free0) begin
        v0_q <= s_axis_tvalid;
      end
      if (free1) begin
        v1_q <= v0_q;
      end
      if (free2) begin
        v2_q <= v1_q;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (load0) begin
      temp_q  <= signed'(s_axis_tdata[TEMP_W-1:0]);
      now_q   <= s_axis_tdata[TEMP_W +: TIME_W];
      bench_q <= s_axis_tdata[TEMP_W+TIME_W];
    end
  end

  phfc_ctrl #(.DUTY_BITS(DUTY_BITS)) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load1),
    .temp_i          (temp_q),
    .now_i           (now_q),
    .bench_i         (bench_q),
    .on_th_i         (on_th),
    .off_th_i        (off_th),
    .kick_dur_i      (kick_dur),
    .duty_min_i      (duty_min),
    .duty_max_norm_i (duty_max_norm),
    .duty_max_bnch_i (duty_max_bnch),
    .flags_o         (flags),
    .prod_o          (prod)
  );

  phfc_curve #(.DUTY_BITS(DUTY_BITS)) u_curve (
    .clk_i           (clk_i),
    .load_i          (load2),
    .flags_i         (flags),
    .prod_i          (prod),
    .duty_min_i      (duty_min),
    .duty_max_norm_i (duty_max_norm),
    .duty_max_bnch_i (duty_max_bnch),
    .kick_duty_i     (kick_duty),
    .duty_o          (out_duty),
    .pump_on_o       (out_pump_on),
    .kicking_o       (out_kicking)
  );

  assign m_axis_tdata = OUT_W'({out_kicking, out_pump_on, out_duty});

`ifndef ASSERT_OFF
  // A pump that is off drives no duty.
  a_off_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_pump_on |-> out_duty == '0)
    else $error("duty nonzero while pump is off");

  // Kickstart is only reported while the pump is on.
  a_kick_needs_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_kicking |-> out_pump_on)
    else $error("kickstart reported with pump off");

  // The input side stalls only when every stage holds a transaction.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> v0_q && v1_q && v2_q)
    else $error("input stalled with a free pipeline stage");
`endif

endmodule
